>>> rtl/core/timestamped_position_interpolator_macros.svh
// Assertion macros for the timestamped position interpolator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TIMESTAMPED_POSITION_INTERPOLATOR_MACROS_SVH
`define TIMESTAMPED_POSITION_INTERPOLATOR_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge outside of reset.
`define TPI_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tpi assertion failed");
// Checks that a condition implies another condition in the same cycle.
`define TPI_ASSERT_IMPL(label, ante, cons) \
    `TPI_ASSERT(label, (ante) |-> (cons))
`else
`define TPI_ASSERT(label, prop)
`define TPI_ASSERT_IMPL(label, ante, cons)
`endif
`endif

>>> rtl/core/tpi_pkg.sv
// Shared types and constants of the timestamped position interpolator.
// No dependencies; used by tpi_ctrl, tpi_dp and the top level.
`timescale 1ns / 1ps

package tpi_pkg;

    // Operation codes of the input item.
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_INIT  = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_RENDER_DELAY   = 1'b0;
    localparam logic CFG_SMOOTHING_GAIN = 1'b1;

    // Arithmetic constants.
    localparam logic [8:0] GAIN_MAX       = 9'd256;
    localparam logic [4:0] DIV_LAST_STEP  = 5'd16;
    localparam int         FRAC_SHIFT     = 16;
    localparam int         GAIN_SHIFT     = 8;

    // One ring entry.
    typedef struct packed {
        logic        [47:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_open;
        logic cap;
        logic init_wr;
        logic push_wr;
        logic warp_wr_prev;
        logic warp_wr_cur;
        logic rd_newest;
        logic walk_step;
        logic ld_prev;
        logic range;
        logic div_step;
        logic fmul;
        logic tgt_next;
        logic tgt_interp;
        logic gmul;
        logic res;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       warp;
        logic       init_last;
        logic       newest_late;
        logic       walk_stop;
        logic       range_pos;
        logic       div_last;
        logic       out_free;
    } t_sts;

endpackage

>>> rtl/core/tpi_ctrl.sv
// Controller state machine of the timestamped position interpolator.
// Depends on tpi_pkg; drives the command struct of tpi_dp.
`timescale 1ns / 1ps

module tpi_ctrl
    import tpi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_DISP   = 14'h0002,
        S_INIT   = 14'h0004,
        S_WARP2  = 14'h0008,
        S_QNEW   = 14'h0010,
        S_QWALK  = 14'h0020,
        S_QRANGE = 14'h0040,
        S_QSEL   = 14'h0080,
        S_QDIV   = 14'h0100,
        S_QFMUL  = 14'h0200,
        S_QTGT   = 14'h0400,
        S_QGMUL  = 14'h0800,
        S_QOUT   = 14'h1000,
        S_DONE   = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_open = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.func)
                    FUNC_INIT: begin
                        n_state = S_INIT;
                    end
                    FUNC_PUSH: begin
                        if (i_sts.warp) begin
                            o_cmd.warp_wr_prev = 1'b1;
                            n_state            = S_WARP2;
                        end else begin
                            o_cmd.push_wr = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    FUNC_QUERY: begin
                        o_cmd.rd_newest = 1'b1;
                        n_state         = S_QNEW;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_DONE;
                end
            end
            S_WARP2: begin
                o_cmd.warp_wr_cur = 1'b1;
                n_state           = S_DONE;
            end
            S_QNEW: begin
                // The newest sample is older than render time: nothing to do.
                if (i_sts.newest_late) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_QWALK;
                end
            end
            S_QWALK: begin
                if (i_sts.walk_stop) begin
                    o_cmd.ld_prev = 1'b1;
                    n_state       = S_QRANGE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_QRANGE: begin
                o_cmd.range = 1'b1;
                n_state     = S_QSEL;
            end
            S_QSEL: begin
                if (i_sts.range_pos) begin
                    n_state = S_QDIV;
                end else begin
                    o_cmd.tgt_next = 1'b1;
                    n_state        = S_QGMUL;
                end
            end
            S_QDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_QFMUL;
                end
            end
            S_QFMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = S_QTGT;
            end
            S_QTGT: begin
                o_cmd.tgt_interp = 1'b1;
                n_state          = S_QGMUL;
            end
            S_QGMUL: begin
                o_cmd.gmul = 1'b1;
                n_state    = S_QOUT;
            end
            S_QOUT: begin
                o_cmd.res = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tpi_dp.sv
// Datapath of the timestamped position interpolator: ring memory, walk
// pointers, serial divider, multipliers and output register. Uses tpi_pkg.
`timescale 1ns / 1ps

module tpi_dp
    import tpi_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_func,
    input  logic [47:0]        i_now_ms,
    input  logic signed [31:0] i_sample_x,
    input  logic signed [31:0] i_sample_y,
    input  logic               i_warp,
    input  logic signed [31:0] i_current_x,
    input  logic signed [31:0] i_current_y,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_moved,
    output logic               o_out_valid,
    input  logic               i_out_stall
);

    localparam int            AW   = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    t_entry              mem [DEPTH];
    t_entry              r_rd;
    t_entry              r_next;
    t_entry              r_prev;
    logic [15:0]         r_delay;
    logic [8:0]          r_gain;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_cnt;
    logic [AW-1:0]       r_pv;
    logic [1:0]          r_func;
    logic                r_warp;
    logic [47:0]         r_now;
    logic [47:0]         r_render;
    logic signed [31:0]  r_sx;
    logic signed [31:0]  r_sy;
    logic signed [31:0]  r_cx;
    logic signed [31:0]  r_cy;
    logic [47:0]         r_range;
    logic [47:0]         r_rem;
    logic [16:0]         r_q;
    logic [4:0]          r_dcnt;
    logic signed [50:0]  r_px;
    logic signed [50:0]  r_py;
    logic signed [31:0]  r_tx;
    logic signed [31:0]  r_ty;
    logic signed [42:0]  r_gx;
    logic signed [42:0]  r_gy;
    logic signed [31:0]  r_res_x;
    logic signed [31:0]  r_res_y;
    logic                r_res_moved;
    logic                r_out_valid;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    logic [47:0]         w_range;
    logic [47:0]         w_num;
    logic [47:0]         w_num_clamp;
    logic                w_ge;
    logic [47:0]         w_sub;
    logic signed [32:0]  w_dx;
    logic signed [32:0]  w_dy;
    logic signed [17:0]  w_fq;
    logic signed [32:0]  w_ex;
    logic signed [32:0]  w_ey;
    logic signed [9:0]   w_g;
    logic [47:0]         w_late_diff;
    logic [47:0]         w_walk_diff;

    // Configuration registers; the port never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= 16'd100;
            r_gain  <= 9'd26;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RENDER_DELAY:   r_delay <= i_cfg_data;
                CFG_SMOOTHING_GAIN: r_gain  <= i_cfg_data[8:0];
                default:            r_delay <= r_delay;
            endcase
        end
    end

    // Ring write port selection.
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_wp;
        w_wdata = '{t: r_now, x: r_sx, y: r_sy};
        if (i_cmd.init_wr) begin
            w_waddr   = r_cnt;
            w_wdata.t = r_now - 48'(DEPTH) + {{(48 - AW){1'b0}}, r_cnt};
        end else if (i_cmd.warp_wr_prev) begin
            w_waddr   = f_prev(r_wp);
            w_wdata.t = r_render;
        end else if (i_cmd.warp_wr_cur) begin
            w_wdata.t = r_render;
        end else if (!i_cmd.push_wr) begin
            w_we = 1'b0;
        end
    end

    // Ring read port: the newest entry first, then one entry older per step.
    assign w_re    = i_cmd.rd_newest | i_cmd.walk_step;
    assign w_raddr = i_cmd.rd_newest ? f_prev(r_wp) : f_prev(r_pv);

    // Ring memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_raddr];
        end
    end

    // Write pointer and init sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_cnt <= '0;
            end else if (i_cmd.init_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.init_wr && r_cnt == LAST) begin
                r_wp <= '0;
            end else if (i_cmd.push_wr || i_cmd.warp_wr_cur) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
        end
    end

    // Input capture and walk pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func   <= i_func;
            r_warp   <= i_warp;
            r_now    <= i_now_ms;
            r_render <= i_now_ms - {32'd0, r_delay};
            r_sx     <= i_sample_x;
            r_sy     <= i_sample_y;
            r_cx     <= i_current_x;
            r_cy     <= i_current_y;
        end
        if (i_cmd.rd_newest) begin
            r_pv <= f_prev(r_wp);
        end else if (i_cmd.walk_step) begin
            r_pv   <= f_prev(r_pv);
            r_next <= r_rd;
        end
        if (i_cmd.ld_prev) begin
            r_prev <= r_rd;
        end
    end

    // Bracket span and clamped offset of render time.
    assign w_range     = r_next.t - r_prev.t;
    assign w_num       = r_render - r_prev.t;
    assign w_num_clamp = w_num[47] ? 48'd0 : ((w_num > w_range) ? w_range : w_num);

    // Restoring divider, one quotient bit per cycle.
    assign w_ge  = (r_rem >= r_range);
    assign w_sub = w_ge ? (r_rem - r_range) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.range) begin
            r_range <= w_range;
            r_rem   <= w_num_clamp;
            r_q     <= '0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= {w_sub[46:0], 1'b0};
            r_q    <= {r_q[15:0], w_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Interpolation and smoothing arithmetic.
    assign w_dx = $signed({r_next.x[31], r_next.x}) - $signed({r_prev.x[31], r_prev.x});
    assign w_dy = $signed({r_next.y[31], r_next.y}) - $signed({r_prev.y[31], r_prev.y});
    assign w_fq = $signed({1'b0, r_q});
    assign w_ex = $signed({r_tx[31], r_tx}) - $signed({r_cx[31], r_cx});
    assign w_ey = $signed({r_ty[31], r_ty}) - $signed({r_cy[31], r_cy});
    assign w_g  = $signed({1'b0, (r_gain > GAIN_MAX) ? GAIN_MAX : r_gain});

    always_ff @(posedge i_clk) begin
        if (i_cmd.fmul) begin
            r_px <= w_dx * w_fq;
            r_py <= w_dy * w_fq;
        end
        if (i_cmd.tgt_next) begin
            r_tx <= r_next.x;
            r_ty <= r_next.y;
        end else if (i_cmd.tgt_interp) begin
            r_tx <= r_prev.x + 32'(r_px >>> FRAC_SHIFT);
            r_ty <= r_prev.y + 32'(r_py >>> FRAC_SHIFT);
        end
        if (i_cmd.gmul) begin
            r_gx <= w_ex * w_g;
            r_gy <= w_ey * w_g;
        end
    end

    // Result of the current item; zero unless a query moves.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_res_x     <= '0;
            r_res_y     <= '0;
            r_res_moved <= 1'b0;
        end else if (i_cmd.res) begin
            r_res_x     <= r_cx + 32'(r_gx >>> GAIN_SHIFT);
            r_res_y     <= r_cy + 32'(r_gy >>> GAIN_SHIFT);
            r_res_moved <= 1'b1;
        end
    end

    // Output register; a waiting result holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_x <= r_res_x;
            o_out_y <= r_res_y;
            o_moved <= r_res_moved;
        end
    end

    assign o_out_valid = r_out_valid;

    // Signed time differences of the entry just read against render time.
    assign w_late_diff = r_rd.t - r_render;
    assign w_walk_diff = r_render - r_rd.t;

    // Status toward the controller.
    always_comb begin
        o_sts.func        = r_func;
        o_sts.warp        = r_warp;
        o_sts.init_last   = (r_cnt == LAST);
        o_sts.newest_late = w_late_diff[47];
        o_sts.walk_stop   = (r_pv == r_wp) || !w_walk_diff[47];
        o_sts.range_pos   = !r_range[47] && (r_range != 48'd0);
        o_sts.div_last    = (r_dcnt == DIV_LAST_STEP);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

>>> rtl/core/timestamped_position_interpolator.sv
// Usage notes
// Input channel i_in_valid / o_in_stall carries one item per transfer: func,
// now_ms, sample and current positions, warp. Each item gives exactly one
// result transfer on o_out_valid / i_out_stall: out_x, out_y and moved.
// Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a
// one-bit index: 0 render delay, 1 smoothing gain; write them only when idle.
// Items are handled one at a time. A query reads the newest ring entry and
// then k (1..DEPTH-1) older entries in a backward walk through the single
// ring read port, then runs the 17-step serial divider, the interpolation
// and the smoothing multiply. A query whose bracket span is zero or negative
// skips the divider. A query whose newest sample is older than render time
// finishes once that entry is read. A plain push is the fastest item, as is
// an unknown operation.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; the controller waits only if a second result
// is ready before the first was taken. Reset clears the write pointer, the
// output valid and the configuration registers to 100 and 26. The ring is
// undefined until the first init.
`timescale 1ns / 1ps
`include "timestamped_position_interpolator_macros.svh"

module timestamped_position_interpolator
    import tpi_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [47:0]        i_now_ms,
    input  logic signed [31:0] i_sample_x,
    input  logic signed [31:0] i_sample_y,
    input  logic               i_warp,
    input  logic signed [31:0] i_current_x,
    input  logic signed [31:0] i_current_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_moved
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencing of each item.
    tpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic.
    tpi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_func      (i_func),
        .i_now_ms    (i_now_ms),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_warp      (i_warp),
        .i_current_x (i_current_x),
        .i_current_y (i_current_y),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_moved     (o_moved),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    assign o_in_stall  = !w_cmd.in_open;
    assign o_cfg_ready = 1'b1;

    // An accepted item closes the input until its result is loaded.
    `TPI_ASSERT(a_in_closes, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // A result is never loaded over one that the receiver has not taken.
    `TPI_ASSERT_IMPL(a_out_no_overwrite, w_cmd.out_load, !o_out_valid || !i_out_stall)
    // The single ring write port serves one write source per cycle.
    `TPI_ASSERT(a_one_writer, $onehot0({w_cmd.init_wr, w_cmd.push_wr, w_cmd.warp_wr_prev, w_cmd.warp_wr_cur}))

endmodule

>>> dv/tpi_checker.sv
// Checker for the timestamped position interpolator: watches the input,
// configuration and result channels, predicts each result and compares it.
// Depends on tpi_pkg for the operation codes and register indexes.
`timescale 1ns / 1ps

module tpi_checker
    import tpi_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_func,
    input  logic [47:0]        i_now_ms,
    input  logic signed [31:0] i_sample_x,
    input  logic signed [31:0] i_sample_y,
    input  logic               i_warp,
    input  logic signed [31:0] i_current_x,
    input  logic signed [31:0] i_current_y,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_out_x,
    input  logic signed [31:0] i_out_y,
    input  logic               i_moved,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               moved;
    } t_pos_result;

    t_pos_result        expected_pos_q[$];
    logic [47:0]        ring_t[DEPTH];
    logic signed [31:0] ring_x[DEPTH];
    logic signed [31:0] ring_y[DEPTH];
    int                 wr_ptr;
    logic [15:0]        delay_ms;
    logic [8:0]         gain;
    int                 fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_pos_q.size();

    // Signed 48-bit time difference b - a.
    function automatic longint time_delta(logic [47:0] b, logic [47:0] a);
        logic signed [47:0] d;
        d = b - a;
        return d;
    endfunction

    // Updates the ring copy for one item and returns the position it yields.
    function automatic t_pos_result interpolate_item(logic [1:0] func, logic [47:0] now,
            logic signed [31:0] sx, logic signed [31:0] sy, logic warp,
            logic signed [31:0] cx, logic signed [31:0] cy);
        t_pos_result            res;
        logic [47:0]            render;
        int                     nx;
        int                     pv;
        bit                     done;
        longint                 span;
        longint                 num;
        longint unsigned        numu;
        longint                 f;
        longint                 tx;
        longint                 ty;
        longint                 g;
        longint                 ox;
        longint                 oy;
        res.x = '0;
        res.y = '0;
        res.moved = 1'b0;
        render = now - {32'd0, delay_ms};
        case (func)
            FUNC_INIT: begin
                for (int i = 0; i < DEPTH; i++) begin
                    ring_t[i] = now - 48'(DEPTH) + 48'(i);
                    ring_x[i] = sx;
                    ring_y[i] = sy;
                end
                wr_ptr = 0;
            end
            FUNC_PUSH: begin
                if (warp) begin
                    pv = (wr_ptr + DEPTH - 1) % DEPTH;
                    ring_t[pv] = render;
                    ring_x[pv] = sx;
                    ring_y[pv] = sy;
                    ring_t[wr_ptr] = render;
                end else begin
                    ring_t[wr_ptr] = now;
                end
                ring_x[wr_ptr] = sx;
                ring_y[wr_ptr] = sy;
                wr_ptr = (wr_ptr + 1) % DEPTH;
            end
            FUNC_QUERY: begin
                nx = (wr_ptr + DEPTH - 1) % DEPTH;
                if (time_delta(ring_t[nx], render) >= 0) begin
                    // Walk back until the older entry is not later than render time.
                    done = 1'b0;
                    pv = nx;
                    while (!done) begin
                        pv = (nx + DEPTH - 1) % DEPTH;
                        if (pv == wr_ptr || time_delta(render, ring_t[pv]) >= 0)
                            done = 1'b1;
                        else
                            nx = pv;
                    end
                    span = time_delta(ring_t[nx], ring_t[pv]);
                    if (span > 0) begin
                        num = time_delta(render, ring_t[pv]);
                        if (num < 0)
                            num = 0;
                        if (num > span)
                            num = span;
                        numu = num;
                        f = (numu << 16) / longint'(span);
                        tx = longint'(ring_x[pv])
                            + (((longint'(ring_x[nx]) - longint'(ring_x[pv])) * f) >>> 16);
                        ty = longint'(ring_y[pv])
                            + (((longint'(ring_y[nx]) - longint'(ring_y[pv])) * f) >>> 16);
                    end else begin
                        tx = ring_x[nx];
                        ty = ring_y[nx];
                    end
                    g = (gain > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain);
                    ox = longint'(cx) + (((tx - longint'(cx)) * g) >>> 8);
                    oy = longint'(cy) + (((ty - longint'(cy)) * g) >>> 8);
                    res.x = ox[31:0];
                    res.y = oy[31:0];
                    res.moved = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Compare finished transfers first, then predict the newly accepted item.
    always @(posedge i_clk) begin
        t_pos_result exp_pos;
        t_pos_result pred_pos;
        if (!i_rst_n) begin
            expected_pos_q.delete();
            for (int i = 0; i < DEPTH; i++) begin
                ring_t[i] = '0;
                ring_x[i] = '0;
                ring_y[i] = '0;
            end
            wr_ptr = 0;
            delay_ms = 16'd100;
            gain = 9'd26;
            fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_pos_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                end else begin
                    exp_pos = expected_pos_q.pop_front();
                    if (exp_pos.x !== i_out_x || exp_pos.y !== i_out_y
                            || exp_pos.moved !== i_moved) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp x=%0d y=%0d moved=%0b",
                                " got x=%0d y=%0d moved=%0b"},
                                $realtime, exp_pos.x, exp_pos.y, exp_pos.moved,
                                i_out_x, i_out_y, i_moved);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RENDER_DELAY)
                    delay_ms = i_cfg_data;
                else
                    gain = i_cfg_data[8:0];
            end
            if (i_in_valid && !i_in_stall) begin
                pred_pos = interpolate_item(i_func, i_now_ms, i_sample_x,
                    i_sample_y, i_warp, i_current_x, i_current_y);
                expected_pos_q.insert(expected_pos_q.size(), pred_pos);
            end
        end
    end

endmodule

>>> dv/tb_top.sv
// Top of the interpolator testbench: clock, reset, stimulus and verdict.
// Depends on tpi_pkg, the timestamped_position_interpolator RTL and tpi_checker.
`timescale 1ns / 1ps

module tb_top;
    import tpi_pkg::*;

    localparam int DEPTH = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = FUNC_PUSH;
    logic [47:0]        i_now_ms = '0;
    logic signed [31:0] i_sample_x = '0;
    logic signed [31:0] i_sample_y = '0;
    logic               i_warp = 1'b0;
    logic signed [31:0] i_current_x = '0;
    logic signed [31:0] i_current_y = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_RENDER_DELAY;
    logic [15:0]        i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_moved;
    int                 fail_count;
    int                 pending;

    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;
    logic [47:0]        clock_ms = '0;
    logic [15:0]        cur_delay = 16'd100;

    always #5 i_clk = ~i_clk;

    timestamped_position_interpolator #(.DEPTH(DEPTH)) u_dut (.*);

    tpi_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_func(i_func), .i_now_ms(i_now_ms), .i_sample_x(i_sample_x),
        .i_sample_y(i_sample_y), .i_warp(i_warp), .i_current_x(i_current_x),
        .i_current_y(i_current_y), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_moved(o_moved), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_done = 1'b1;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 27);
        end
    end

    // Offers one item and waits for its transfer.
    task automatic offer_item(logic [1:0] func, logic [47:0] now, logic [31:0] sx,
            logic [31:0] sy, logic warp, logic [31:0] cx, logic [31:0] cy);
        if (!calm && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_now_ms    <= now;
        i_sample_x  <= sx;
        i_sample_y  <= sy;
        i_warp      <= warp;
        i_current_x <= cx;
        i_current_y <= cy;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Writes one register once every expected result has come back.
    task automatic write_reg(logic idx, logic [15:0] data);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_RENDER_DELAY)
            cur_delay = data;
    endtask

    // One random item: mostly pushes and in-window queries.
    task automatic random_item();
        int          r;
        logic [47:0] now;
        logic [31:0] sx;
        logic [31:0] sy;
        r = $urandom_range(0, 99);
        sx = $urandom();
        sy = $urandom();
        if ($urandom_range(0, 1) == 0) begin
            sx = $signed(i_sample_x) + $signed(20'($urandom()));
            sy = $signed(i_sample_y) + $signed(20'($urandom()));
        end
        if (r < 3) begin
            now = 48'({$urandom(), $urandom()});
            clock_ms = now;
            offer_item(FUNC_INIT, now, sx, sy, 1'($urandom()), $urandom(), $urandom());
        end else if (r < 45) begin
            // Time steps of zero and backward steps give zero and negative spans.
            if ($urandom_range(0, 19) == 0)
                clock_ms = clock_ms - $urandom_range(1, 30);
            else
                clock_ms = clock_ms + $urandom_range(0, 60);
            offer_item(FUNC_PUSH, clock_ms, sx, sy, $urandom_range(0, 9) == 0,
                $urandom(), $urandom());
        end else if (r < 95) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                now = clock_ms + cur_delay - $urandom_range(0, 320);
            else if (r < 90)
                now = clock_ms + cur_delay + $urandom_range(1, 100);
            else
                now = 48'({$urandom(), $urandom()});
            offer_item(FUNC_QUERY, now, $urandom(), $urandom(), 1'($urandom()),
                $urandom(), $urandom());
        end else begin
            offer_item(FUNC_RSVD, 48'({$urandom(), $urandom()}), sx, sy, 1'($urandom()),
                $urandom(), $urandom());
        end
    endtask

    initial begin
        logic [15:0] delays[5];
        logic [15:0] gains[5];
        delays = '{16'd100, 16'd0, 16'd65535, 16'd37, 16'd250};
        gains  = '{16'd26, 16'd256, 16'd0, 16'h01FF, 16'd128};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes at reset settings, time wrap, warp, unknown operation.
        offer_item(FUNC_INIT, 48'd0, 32'h7FFFFFFF, 32'h80000000, 1'b1, '0, '0);
        offer_item(FUNC_QUERY, 48'd0, '0, '0, 1'b1, 32'h80000000, 32'h7FFFFFFF);
        offer_item(FUNC_QUERY, 48'd95, '0, '0, 1'b0, 32'h7FFFFFFF, 32'h80000000);
        offer_item(FUNC_PUSH, 48'd10, 32'h80000000, 32'h7FFFFFFF, 1'b0, '1, '1);
        offer_item(FUNC_PUSH, 48'd30, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0, '0);
        offer_item(FUNC_QUERY, 48'd120, '0, '0, 1'b0, 32'h80000000, 32'h80000000);
        offer_item(FUNC_QUERY, 48'd200, '0, '0, 1'b0, '0, '0);
        offer_item(FUNC_PUSH, 48'd150, 32'h00001000, 32'hFFFFF000, 1'b1, '0, '0);
        offer_item(FUNC_QUERY, 48'd150, '0, '0, 1'b0, 32'h7FFFFFFF, 32'h80000000);
        offer_item(FUNC_PUSH, 48'd150, 32'h00002000, 32'h00002000, 1'b0, '0, '0);
        offer_item(FUNC_QUERY, 48'd250, '0, '0, 1'b0, '0, '0);
        offer_item(FUNC_RSVD, 48'hFFFFFFFFFFFF, '1, '1, 1'b1, '1, '1);
        offer_item(FUNC_QUERY, 48'd250, '0, '0, 1'b0, '0, '0);
        offer_item(FUNC_INIT, 48'hFFFFFFFFFFFF, 32'hFFFFFF00, 32'h00000100, 1'b0, '0, '0);
        offer_item(FUNC_PUSH, 48'd2, 32'h00010000, 32'hFFFF0000, 1'b0, '0, '0);
        offer_item(FUNC_QUERY, 48'd100, '0, '0, 1'b0, 32'h12345678, 32'h87654321);
        offer_item(FUNC_QUERY, 48'd101, '0, '0, 1'b0, '0, '0);
        offer_item(FUNC_QUERY, 48'd102, '0, '0, 1'b0, '0, '0);
        clock_ms = 48'd2;

        // Random phases across register settings, extremes included.
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_RENDER_DELAY, delays[p]);
            write_reg(CFG_SMOOTHING_GAIN, gains[p]);
            if (p == 1)
                hold_req = 1'b1;
            for (int n = 0; n < 260; n++) begin
                calm = (p == 2 && n >= 50 && n < 200);
                random_item();
            end
            calm = 1'b0;
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
